// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the sorted extent table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SXT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SXT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sxt_pkg.sv -----
// Types and constants of the sorted extent table.
`default_nettype none

package sxt_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 31;
  localparam int OUT_CNT_W = 11;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_FIND    = 2'd2,
    MODE_COMPACT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic live;
    key_t offset;
    key_t size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   re;
    addr_t  raddr;
  } ram_req_t;

  typedef struct packed {
    status_t  status;
    out_cnt_t entry_count;
    out_cnt_t deleted_count;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sxt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sxt_ctrl.sv -----
// Sequencer: append, binary search, delete and compaction over the entry RAM.
`default_nettype none

`include "assert_macros.svh"

module sxt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_mode,
  input  wire sxt_pkg::key_t    in_extent_offset,
  input  wire sxt_pkg::key_t    in_extent_size,
  output logic                  res_valid,
  output sxt_pkg::res_t         res,
  input  wire logic             res_stall,
  output sxt_pkg::ram_req_t     ram_req,
  input  wire sxt_pkg::entry_t  ram_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_SRCH = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  sxt_pkg::cnt_t    stored_r, stored_nxt;
  sxt_pkg::cnt_t    tomb_r, tomb_nxt;
  logic             pend_r, pend_nxt;
  sxt_pkg::mode_t   mode_r;
  sxt_pkg::key_t    off_r, size_r;
  sxt_pkg::cnt_t    lo_r, lo_nxt;
  sxt_pkg::cnt_t    hi_r, hi_nxt;
  sxt_pkg::cnt_t    mid_r, mid_nxt;
  sxt_pkg::cnt_t    src_r, src_nxt;
  sxt_pkg::cnt_t    dst_r, dst_nxt;
  sxt_pkg::status_t status_r, status_nxt;

  logic             accept;
  logic [2*sxt_pkg::KEY_W-1:0] key, rd_key;
  logic             key_eq, key_gt;
  sxt_pkg::cnt_t    live_cnt;
  sxt_pkg::cnt_t    probe_lo, probe_hi, probe_mid;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign key      = {off_r, size_r};
  assign rd_key   = {ram_rdata.offset, ram_rdata.size};
  assign key_eq   = (rd_key == key);
  assign key_gt   = (rd_key > key);
  assign live_cnt = stored_r - tomb_r;

  assign probe_lo  = key_gt ? lo_r : mid_r + sxt_pkg::cnt_t'(1);
  assign probe_hi  = key_gt ? mid_r : hi_r;
  assign probe_mid = probe_lo + ((probe_hi - probe_lo) >> 1);

  assign res.status        = status_r;
  assign res.entry_count   = sxt_pkg::out_cnt_t'(stored_r);
  assign res.deleted_count = sxt_pkg::out_cnt_t'(tomb_r);

  always_comb begin
    state_nxt  = state_r;
    stored_nxt = stored_r;
    tomb_nxt   = tomb_r;
    pend_nxt   = pend_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    status_nxt = status_r;
    ram_req    = '0;
    res_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (mode_r)
          sxt_pkg::MODE_APPEND: begin
            state_nxt = S_FIN;
            if (stored_r == sxt_pkg::cnt_t'(sxt_pkg::CAPACITY)) begin
              status_nxt = sxt_pkg::ST_FULL;
            end else begin
              status_nxt          = sxt_pkg::ST_OK;
              ram_req.we          = 1'b1;
              ram_req.waddr       = stored_r[sxt_pkg::ADDR_W-1:0];
              ram_req.wdata.live  = 1'b1;
              ram_req.wdata.offset = off_r;
              ram_req.wdata.size  = size_r;
              stored_nxt          = stored_r + sxt_pkg::cnt_t'(1);
            end
          end
          sxt_pkg::MODE_DELETE, sxt_pkg::MODE_FIND: begin
            status_nxt = sxt_pkg::ST_NOT_FOUND;
            lo_nxt     = '0;
            hi_nxt     = stored_r;
            mid_nxt    = stored_r >> 1;
            if (stored_r != '0) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = mid_nxt[sxt_pkg::ADDR_W-1:0];
              state_nxt     = S_SRCH;
            end else begin
              state_nxt = S_FIN;
            end
          end
          sxt_pkg::MODE_COMPACT: begin
            status_nxt = sxt_pkg::ST_OK;
            src_nxt    = '0;
            dst_nxt    = '0;
            pend_nxt   = 1'b0;
            if (live_cnt > tomb_r) begin
              state_nxt = S_FIN;
            end else if (live_cnt == '0) begin
              stored_nxt = '0;
              tomb_nxt   = '0;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SRCH: begin
        if (key_eq) begin
          state_nxt = S_FIN;
          if (ram_rdata.live) begin
            status_nxt = sxt_pkg::ST_OK;
            if (mode_r == sxt_pkg::MODE_DELETE) begin
              ram_req.we           = 1'b1;
              ram_req.waddr        = mid_r[sxt_pkg::ADDR_W-1:0];
              ram_req.wdata.live   = 1'b0;
              ram_req.wdata.offset = off_r;
              ram_req.wdata.size   = size_r;
              tomb_nxt             = tomb_r + sxt_pkg::cnt_t'(1);
            end
          end
        end else if (probe_lo < probe_hi) begin
          lo_nxt        = probe_lo;
          hi_nxt        = probe_hi;
          mid_nxt       = probe_mid;
          ram_req.re    = 1'b1;
          ram_req.raddr = probe_mid[sxt_pkg::ADDR_W-1:0];
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (pend_r && ram_rdata.live) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = dst_r[sxt_pkg::ADDR_W-1:0];
          ram_req.wdata = ram_rdata;
          dst_nxt       = dst_r + sxt_pkg::cnt_t'(1);
        end
        if (src_r < stored_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = src_r[sxt_pkg::ADDR_W-1:0];
          src_nxt       = src_r + sxt_pkg::cnt_t'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            stored_nxt = dst_r;
            tomb_nxt   = '0;
            state_nxt  = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!res_stall) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stored_r <= '0;
      tomb_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stored_r <= stored_nxt;
      tomb_r   <= tomb_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= sxt_pkg::mode_t'(in_mode);
      off_r  <= in_extent_offset;
      size_r <= in_extent_size;
    end
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    status_r <= status_nxt;
  end

  `SXT_IMPLIES(a_tomb_le_stored, 1'b1, tomb_r <= stored_r, "deleted count above entry count")
  `SXT_IMPLIES(a_stored_le_cap, 1'b1, stored_r <= sxt_pkg::cnt_t'(sxt_pkg::CAPACITY), "entry count above capacity")
  `SXT_IMPLIES(a_probe_in_range, state_r == S_SRCH, (lo_r <= mid_r) && (mid_r < hi_r) && (hi_r <= stored_r), "search probe outside range")
  `SXT_IMPLIES(a_scan_write_behind, (state_r == S_SCAN) && ram_req.we, dst_r < src_r, "compaction write overtakes read")

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_extent_table_unit.sv -----
// Sorted extent table top level: sequencer, entry RAM and result register.
// Append, and compact without a walk: dispatch, then finish, then registered out_valid.
// Find and delete: dispatch, up to clog2(entry_count) + 1 search probes, then finish.
// Compact walk: one RAM read per cycle; live entries are packed down in order.
// One word in flight; the next word is taken once the current result is registered.
// Reset clears counts and control; RAM contents are left as is and never read unwritten.
`default_nettype none

`include "assert_macros.svh"

module sorted_extent_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [30:0] in_extent_offset,
  input  wire logic [30:0] in_extent_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [10:0]      out_entry_count,
  output logic [10:0]      out_deleted_count
);

  logic              res_valid;
  logic              res_stall;
  sxt_pkg::res_t     res;
  sxt_pkg::res_t     out_res_r;
  logic              out_valid_r;
  sxt_pkg::ram_req_t ram_req;
  sxt_pkg::entry_t   ram_rdata;

  assign res_stall = out_valid_r && out_stall;

  sxt_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_extent_offset (in_extent_offset),
    .in_extent_size   (in_extent_size),
    .res_valid        (res_valid),
    .res              (res),
    .res_stall        (res_stall),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata)
  );

  sxt_ram #(
    .WIDTH (sxt_pkg::ENTRY_W),
    .DEPTH (sxt_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.we),
    .wr_addr (ram_req.waddr),
    .wr_data (ram_req.wdata),
    .rd_en   (ram_req.re),
    .rd_addr (ram_req.raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_entry_count   = out_res_r.entry_count;
  assign out_deleted_count = out_res_r.deleted_count;

  `SXT_IMPLIES(a_no_overwrite, res_valid, !(out_valid_r && out_stall), "result overwrites a held word")

endmodule

`default_nettype wire
